FILE: rtl/json_string_escaper_utf8_check_assert.svh
// ----------------------------------------------------------------------------
// JSON string escaper assertion macros
// Shared concurrent assertion forms, clocked on clk, idle in reset.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_ESCAPER_UTF8_CHECK_ASSERT_SVH
`define JSON_STRING_ESCAPER_UTF8_CHECK_ASSERT_SVH

// same-cycle implication
`define JSESC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JSESC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/jsesc_pkg.sv
// ----------------------------------------------------------------------------
// JSON string escaper package
// Controller states, command and status groups, character constants.
// ----------------------------------------------------------------------------
package jsesc_pkg;

    localparam int BURST_DEPTH = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int HELD_DEPTH  = 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_FINISH,
        ST_END
    } jsesc_state_t;

    typedef struct packed {
        logic start;
        logic feed;
        logic fail;
        logic close;
        logic flush;
    } jsesc_cmd_t;

    typedef struct packed {
        logic burst_empty;
        logic pq_empty;
        logic held_empty;
        logic fin_req;
        logic flush_ok;
    } jsesc_stat_t;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] LTR_B      = 8'h62;
    localparam logic [7:0] LTR_F      = 8'h66;
    localparam logic [7:0] LTR_N      = 8'h6E;
    localparam logic [7:0] LTR_R      = 8'h72;
    localparam logic [7:0] LTR_T      = 8'h74;
    localparam logic [7:0] LTR_U      = 8'h75;
    localparam logic [7:0] LTR_ZERO   = 8'h30;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    localparam logic [7:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    localparam logic [7:0] LEAD_C2  = 8'hC2;
    localparam logic [7:0] LEAD_DF  = 8'hDF;
    localparam logic [7:0] LEAD_E0  = 8'hE0;
    localparam logic [7:0] LEAD_ED  = 8'hED;
    localparam logic [7:0] LEAD_EF  = 8'hEF;
    localparam logic [7:0] LEAD_F0  = 8'hF0;
    localparam logic [7:0] LEAD_F4  = 8'hF4;
    localparam logic [7:0] CONT_MIN = 8'h80;
    localparam logic [7:0] CONT_MAX = 8'hBF;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] E0_MIN   = 8'hA0;
    localparam logic [7:0] ED_MAX   = 8'h9F;
    localparam logic [7:0] F0_MIN   = 8'h90;
    localparam logic [7:0] F4_MAX   = 8'h8F;

    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

endpackage

FILE: rtl/jsesc_ctrl.sv
// ----------------------------------------------------------------------------
// JSON string escaper controller
// Sequences accept, feed, finish and flush actions on the datapath.
// ----------------------------------------------------------------------------
module jsesc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  jsesc_pkg::jsesc_stat_t stat,
    output jsesc_pkg::jsesc_cmd_t  cmd
);
    import jsesc_pkg::*;

    jsesc_state_t state_reg;
    jsesc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_FEED;
                end
            end
            ST_FEED:
            begin
                if (stat.pq_empty)
                begin
                    state_next = stat.fin_req ? ST_FINISH : ST_END;
                end
            end
            ST_FINISH:
            begin
                if (stat.burst_empty)
                begin
                    state_next = stat.held_empty ? ST_END : ST_FEED;
                end
            end
            ST_END:
            begin
                if (stat.burst_empty && stat.flush_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        cmd       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
            end
            ST_FEED:
            begin
                cmd.feed = !stat.pq_empty && stat.burst_empty;
            end
            ST_FINISH:
            begin
                cmd.fail  = stat.burst_empty && !stat.held_empty;
                cmd.close = stat.burst_empty && stat.held_empty;
            end
            ST_END:
            begin
                cmd.flush = stat.burst_empty && stat.flush_ok;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/jsesc_dp.sv
// ----------------------------------------------------------------------------
// JSON string escaper datapath
// Feed queue, UTF-8 hold buffer, escape burst, one-word stage and output word.
// ----------------------------------------------------------------------------
`include "json_string_escaper_utf8_check_assert.svh"

module jsesc_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  jsesc_pkg::jsesc_cmd_t  cmd,
    output jsesc_pkg::jsesc_stat_t stat,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tlast,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast
);
    import jsesc_pkg::*;

    typedef struct packed {
        logic [BURST_DEPTH-1:0][7:0] bytes;
        logic [2:0]                  cnt;
    } burst_t;

    function automatic burst_t esc_burst(input logic [7:0] c);
        burst_t r;
        r          = '0;
        r.cnt      = 3'd2;
        r.bytes[0] = CH_BSLASH;
        case (c)
            CH_QUOTE:  r.bytes[1] = CH_QUOTE;
            CH_BSLASH: r.bytes[1] = CH_BSLASH;
            CH_BS:     r.bytes[1] = LTR_B;
            CH_FF:     r.bytes[1] = LTR_F;
            CH_LF:     r.bytes[1] = LTR_N;
            CH_CR:     r.bytes[1] = LTR_R;
            CH_TAB:    r.bytes[1] = LTR_T;
            default:
            begin
                if (c < CTRL_LIMIT)
                begin
                    r.bytes[1] = LTR_U;
                    r.bytes[2] = LTR_ZERO;
                    r.bytes[3] = LTR_ZERO;
                    r.bytes[4] = HEX_DIGITS[c[7:4]];
                    r.bytes[5] = HEX_DIGITS[c[3:0]];
                    r.cnt      = 3'd6;
                end
                else
                begin
                    r.bytes[0] = c;
                    r.cnt      = 3'd1;
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [2:0] lead_need(input logic [7:0] c);
        logic [2:0] n;
        case (c) inside
            [LEAD_C2:LEAD_DF]: n = 3'd2;
            [LEAD_E0:LEAD_EF]: n = 3'd3;
            [LEAD_F0:LEAD_F4]: n = 3'd4;
            default:           n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic fits_pos(input logic [7:0] lead, input logic [1:0] p,
                                      input logic [7:0] b);
        logic r;
        r = ((b & CONT_MASK) == CONT_MIN);
        if (p == 2'd1)
        begin
            case (lead)
                LEAD_E0: r = (b >= E0_MIN) && (b <= CONT_MAX);
                LEAD_ED: r = (b >= CONT_MIN) && (b <= ED_MAX);
                LEAD_F0: r = (b >= F0_MIN) && (b <= CONT_MAX);
                LEAD_F4: r = (b >= CONT_MIN) && (b <= F4_MAX);
                default: r = ((b & CONT_MASK) == CONT_MIN);
            endcase
        end
        return r;
    endfunction

    logic [BURST_DEPTH-1:0][7:0] burst_reg, burst_next;
    logic [2:0]                  burst_cnt_reg, burst_cnt_next;
    logic [QUEUE_DEPTH-1:0][7:0] pq_reg, pq_next;
    logic [2:0]                  pq_cnt_reg, pq_cnt_next;
    logic [HELD_DEPTH-1:0][7:0]  held_reg, held_next;
    logic [1:0]                  hc_reg, hc_next;
    logic [2:0]                  need_reg, need_next;
    logic                        inside_reg, inside_next;
    logic                        fin_req_reg, fin_req_next;
    logic                        empty_reg, empty_next;
    logic [7:0]                  stage_byte_reg, stage_byte_next;
    logic                        stage_valid_reg, stage_valid_next;
    logic [7:0]                  out_byte_reg, out_byte_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_valid_reg, out_valid_next;

    logic       out_free;
    logic       shift_en;
    logic [7:0] fb;
    logic [1:0] pos;
    logic       fit;
    logic [2:0] need_v;
    logic       do_fail;
    logic       complete;
    burst_t     esc_v;
    burst_t     ld;
    logic       ld_en;

    always_comb
    begin
        out_free = !out_valid_reg || m_tready;
        shift_en = (burst_cnt_reg != 3'd0) && (!stage_valid_reg || out_free);
        fb       = pq_reg[0];
        pos      = hc_reg;
        fit      = fits_pos(held_reg[0], pos, fb);
        need_v   = lead_need(fb);
        esc_v    = esc_burst(fb);
        complete = (({1'b0, pos} + 3'd1) >= need_reg);
        do_fail  = cmd.fail || (cmd.feed && (pos != 2'd0) && !fit);

        burst_next       = burst_reg;
        burst_cnt_next   = burst_cnt_reg;
        pq_next          = pq_reg;
        pq_cnt_next      = pq_cnt_reg;
        held_next        = held_reg;
        hc_next          = hc_reg;
        need_next        = need_reg;
        inside_next      = inside_reg;
        fin_req_next     = fin_req_reg;
        empty_next       = empty_reg;
        stage_byte_next  = stage_byte_reg;
        stage_valid_next = stage_valid_reg;
        out_byte_next    = out_byte_reg;
        out_last_next    = out_last_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        ld               = '0;
        ld_en            = 1'b0;

        // advance the stage word to the output register
        if (shift_en && stage_valid_reg)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = stage_byte_reg;
            out_last_next  = 1'b0;
        end
        if (cmd.flush && stage_valid_reg)
        begin
            out_valid_next   = 1'b1;
            out_byte_next    = stage_byte_reg;
            out_last_next    = 1'b1;
            stage_valid_next = 1'b0;
        end
        if (shift_en)
        begin
            burst_next       = burst_reg >> 8;
            burst_cnt_next   = burst_cnt_reg - 3'd1;
            stage_byte_next  = burst_reg[0];
            stage_valid_next = 1'b1;
        end

        if (cmd.start)
        begin
            pq_next[0]   = s_tdata;
            pq_cnt_next  = s_tuser ? 3'd0 : 3'd1;
            empty_next   = s_tuser;
            fin_req_next = s_tuser ? inside_reg : s_tlast;
            if (!inside_reg)
            begin
                ld_en       = 1'b1;
                ld.bytes[0] = CH_QUOTE;
                ld.bytes[1] = CH_QUOTE;
                ld.cnt      = s_tuser ? 3'd2 : 3'd1;
                inside_next = !s_tuser;
            end
        end

        if (cmd.feed && !do_fail)
        begin
            pq_next     = pq_reg >> 8;
            pq_cnt_next = pq_cnt_reg - 3'd1;
            if (pos == 2'd0)
            begin
                if (fb[7])
                begin
                    if (need_v == 3'd0)
                    begin
                        ld_en       = 1'b1;
                        ld.bytes[0] = REPL_B0;
                        ld.bytes[1] = REPL_B1;
                        ld.bytes[2] = REPL_B2;
                        ld.cnt      = 3'd3;
                    end
                    else
                    begin
                        held_next[0] = fb;
                        hc_next      = 2'd1;
                        need_next    = need_v;
                    end
                end
                else
                begin
                    ld_en = 1'b1;
                    ld    = esc_v;
                end
            end
            else if (complete)
            begin
                ld_en       = 1'b1;
                hc_next     = 2'd0;
                need_next   = 3'd0;
                ld.bytes[0] = held_reg[0];
                case (pos)
                    2'd1:
                    begin
                        ld.bytes[1] = fb;
                        ld.cnt      = 3'd2;
                    end
                    2'd2:
                    begin
                        ld.bytes[1] = held_reg[1];
                        ld.bytes[2] = fb;
                        ld.cnt      = 3'd3;
                    end
                    default:
                    begin
                        ld.bytes[1] = held_reg[1];
                        ld.bytes[2] = held_reg[2];
                        ld.bytes[3] = fb;
                        ld.cnt      = 3'd4;
                    end
                endcase
            end
            else
            begin
                held_next[pos] = fb;
                hc_next        = pos + 2'd1;
            end
        end

        // replace the lead, requeue the bytes held after it
        if (do_fail)
        begin
            ld_en       = 1'b1;
            ld.bytes[0] = REPL_B0;
            ld.bytes[1] = REPL_B1;
            ld.bytes[2] = REPL_B2;
            ld.cnt      = 3'd3;
            hc_next     = 2'd0;
            need_next   = 3'd0;
            case (hc_reg)
                2'd2:
                begin
                    pq_next     = {pq_reg[2:0], held_reg[1]};
                    pq_cnt_next = pq_cnt_reg + 3'd1;
                end
                2'd3:
                begin
                    pq_next     = {pq_reg[1:0], held_reg[2], held_reg[1]};
                    pq_cnt_next = pq_cnt_reg + 3'd2;
                end
                default:
                begin
                    pq_next     = pq_reg;
                    pq_cnt_next = pq_cnt_reg;
                end
            endcase
        end

        if (cmd.close)
        begin
            ld_en       = 1'b1;
            ld.bytes[0] = CH_QUOTE;
            ld.bytes[1] = CH_QUOTE;
            ld.bytes[2] = CH_QUOTE;
            ld.cnt      = empty_reg ? 3'd3 : 3'd1;
            inside_next = 1'b0;
        end

        if (ld_en)
        begin
            burst_next     = ld.bytes;
            burst_cnt_next = ld.cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_cnt_reg   <= '0;
            pq_cnt_reg      <= '0;
            hc_reg          <= '0;
            need_reg        <= '0;
            inside_reg      <= 1'b0;
            fin_req_reg     <= 1'b0;
            empty_reg       <= 1'b0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            burst_cnt_reg   <= burst_cnt_next;
            pq_cnt_reg      <= pq_cnt_next;
            hc_reg          <= hc_next;
            need_reg        <= need_next;
            inside_reg      <= inside_next;
            fin_req_reg     <= fin_req_next;
            empty_reg       <= empty_next;
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        burst_reg      <= burst_next;
        pq_reg         <= pq_next;
        held_reg       <= held_next;
        stage_byte_reg <= stage_byte_next;
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
    end

    assign stat.burst_empty = (burst_cnt_reg == 3'd0);
    assign stat.pq_empty    = (pq_cnt_reg == 3'd0);
    assign stat.held_empty  = (hc_reg == 2'd0);
    assign stat.fin_req     = fin_req_reg;
    assign stat.flush_ok    = !stage_valid_reg || out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    `JSESC_ASSERT_IMP(a_load_on_empty_burst, (cmd.feed || cmd.fail || cmd.close),
        (burst_cnt_reg == 3'd0), "burst loaded while still draining")
    `JSESC_ASSERT_IMP(a_byte_budget, 1'b1,
        (({1'b0, hc_reg} + pq_cnt_reg) <= 3'd4), "held and queued bytes exceed four")
    `JSESC_ASSERT_NXT(a_flush_clears_stage, cmd.flush,
        (!stage_valid_reg), "stage word left after flush")
    `JSESC_ASSERT_IMP(a_start_idle_dp, cmd.start,
        (pq_cnt_reg == 3'd0 && hc_reg == 2'd0 || pq_cnt_reg == 3'd0) && !stage_valid_reg,
        "item started with work pending")

endmodule

FILE: rtl/json_string_escaper_utf8_check.sv
// ----------------------------------------------------------------------------
// JSON string escaper with UTF-8 check - top level
// Path: an accepted byte goes through the feed queue, the escape burst, the
// stage word and the output word; a held or failed UTF-8 lead delays it.
// A new item is accepted only after the previous one has been flushed
// to the output word; m_tready low stalls the input.
// Reset clears all control state; the first item is taken right after.
// ----------------------------------------------------------------------------
module json_string_escaper_utf8_check (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    input  logic       s_tuser,   // [0] empty_string
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);
    import jsesc_pkg::*;

    jsesc_cmd_t  cmd;
    jsesc_stat_t stat;

    jsesc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    jsesc_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
